// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the planner.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n are implied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/frp_pkg.sv -----
// Shared types and codes of the FFT radix factor planner.
// No dependencies.
`default_nettype none
package frp_pkg;

    typedef enum logic [1:0] {
        CFG_DIRECT_LIMIT = 2'd0,
        CFG_MERGE_BOUND  = 2'd1,
        CFG_MAX_STAGES   = 2'd2,
        CFG_ALPHA        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_ERR    = 2'd0,
        KIND_DIRECT = 2'd1,
        KIND_PLAN   = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [31:0] direct_limit;
        logic [31:0] merge_bound;
        logic [3:0]  max_stages;
        logic [31:0] alpha_threshold;
    } cfg_t;

    localparam logic [31:0] RST_DIRECT_LIMIT = 32'd128;
    localparam logic [31:0] RST_MERGE_BOUND  = 32'd128;
    localparam logic [3:0]  RST_MAX_STAGES   = 4'd8;
    localparam logic [31:0] RST_ALPHA        = 32'd16;

endpackage
`default_nettype wire

// ----- rtl/core/fft_radix_factor_planner_top.sv -----
// Top level of the FFT radix factor planner: configuration registers, front, queue, back.
// Depends on frp_pkg, frp_front, frp_fifo and frp_back.
//
// Takes an FFT length and answers with one item per stage of a mixed-radix plan
// (radix, product of earlier radices, index, last flag), or one error item for a
// length below 2. Lengths up to direct_limit give a single stage. Longer ones are
// factored by trial division over divisors 2..sqrt(n); each trial is a restoring
// divide of LENGTH_BITS quotient bits, so the divider loop sets the time per item:
// longest for a prime n, far less for smooth lengths, plus the merging and
// sorting over at most LENGTH_BITS+1 factors held in memories with a registered
// read. A two-entry queue holds tagged lengths so the input side keeps accepting
// while a plan runs, until the queue is full.
`default_nettype none
module fft_radix_factor_planner_top
    import frp_pkg::*;
#(
    parameter int MAX_STAGE_SLOTS = 8,
    parameter int LENGTH_BITS     = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [31:0]            cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [LENGTH_BITS-1:0] length,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 stage_factor,
    output logic [31:0]                 stride_before,
    output logic [2:0]                  stage_index,
    output logic                        last,
    output logic                        error
);
    cfg_t                   cfg_reg;
    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    logic [LENGTH_BITS+1:0] q_wdata;
    logic [LENGTH_BITS+1:0] q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direct_limit    <= RST_DIRECT_LIMIT;
            cfg_reg.merge_bound     <= RST_MERGE_BOUND;
            cfg_reg.max_stages      <= RST_MAX_STAGES;
            cfg_reg.alpha_threshold <= RST_ALPHA;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DIRECT_LIMIT: cfg_reg.direct_limit    <= cfg_wdata;
                CFG_MERGE_BOUND:  cfg_reg.merge_bound     <= cfg_wdata;
                CFG_MAX_STAGES:   cfg_reg.max_stages      <= cfg_wdata[3:0];
                CFG_ALPHA:        cfg_reg.alpha_threshold <= cfg_wdata;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    frp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .length   (length),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    frp_fifo #(.W(LENGTH_BITS + 2)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    frp_back #(
        .LENGTH_BITS     (LENGTH_BITS),
        .MAX_STAGE_SLOTS (MAX_STAGE_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stage_factor  (stage_factor),
        .stride_before (stride_before),
        .stage_index   (stage_index),
        .last          (last),
        .error         (error)
    );
endmodule
`default_nettype wire

// ----- rtl/core/frp_mul.sv -----
// Shift-add multiplier, one operand bit per cycle, product kept to W bits.
// Depends on nothing; used by frp_back.
`default_nettype none
module frp_mul #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic [W-1:0]      p
);
    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    a_reg;
    logic [W-1:0]    b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

// ----- rtl/core/frp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by frp_back for trial division.
`default_nettype none
module frp_div #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quo,
    output logic [W-1:0]      rem
);
    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    q_reg;
    logic [W-1:0]    r_reg;
    logic [W-1:0]    d_reg;
    logic [W:0]      trial;
    logic [W:0]      diff;

    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_reg <= diff[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

// ----- rtl/core/frp_fifo.sv -----
// Two-entry queue between the classifying front and the planning back.
// Depends on nothing.
`default_nettype none
module frp_fifo #(
    parameter int W = 34
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic              empty,
    output logic [W-1:0]      rdata
);
    logic [W-1:0] slot_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;
    logic         do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/frp_front.sv -----
// Front end: takes items and tags each as error, direct or needing a plan.
// Depends on frp_pkg; feeds frp_fifo.
`default_nettype none
module frp_front
    import frp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [LENGTH_BITS-1:0] length,
    input  wire cfg_t                   cfg,
    input  wire logic                   q_full,
    output logic                        q_push,
    output logic [LENGTH_BITS+1:0]      q_data
);
    item_kind_t               kind;
    logic [LENGTH_BITS+31:0]  len_w;
    logic [LENGTH_BITS+31:0]  lim_w;

    assign len_w = {32'b0, length};
    assign lim_w = {{LENGTH_BITS{1'b0}}, cfg.direct_limit};

    always_comb
    begin
        if (length < LENGTH_BITS'(2))
        begin
            kind = KIND_ERR;
        end
        else if (len_w <= lim_w)
        begin
            kind = KIND_DIRECT;
        end
        else
        begin
            kind = KIND_PLAN;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid;
    assign q_data   = {kind, length};
endmodule
`default_nettype wire

// ----- rtl/core/frp_back.sv -----
// Back end: trial division, greedy merge, sort, stage limiting, alpha swap, emit.
// Depends on frp_pkg, frp_mul and frp_div.
`default_nettype none
module frp_back
    import frp_pkg::*;
#(
    parameter int LENGTH_BITS     = 32,
    parameter int MAX_STAGE_SLOTS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   q_empty,
    input  wire logic [LENGTH_BITS+1:0] q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 stage_factor,
    output logic [31:0]                 stride_before,
    output logic [2:0]                  stage_index,
    output logic                        last,
    output logic                        error
);
    localparam int LB = LENGTH_BITS;
    localparam int PS = LENGTH_BITS + 1;
    localparam int AW = $clog2(PS);
    localparam int CW = $clog2(PS + 1);
    localparam int XW = CW + 5;

    typedef enum logic [5:0] {
        ST_IDLE, ST_FAC, ST_FAC_DIV,
        ST_MRG_START, ST_MRG_RD, ST_MRG_WAIT, ST_MRG_CHK, ST_MRG_MUL,
        ST_SO_TOP, ST_SO_WAIT, ST_SO_GET, ST_SI_RD, ST_SI_WAIT, ST_SI_CHK,
        ST_SWAP1, ST_SWAP2,
        ST_LIM, ST_EX_TOP, ST_EX_RD, ST_EX_WAIT, ST_EX_CHK,
        ST_EX_RDX, ST_EX_WX, ST_EX_MUL, ST_EX_MW,
        ST_AL_RD0, ST_AL_W0, ST_AL_G0, ST_AL_RD, ST_AL_WAIT, ST_AL_CHK, ST_AL_SW2,
        ST_OUT_INIT, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_SET, ST_OUT_HOLD, ST_ERR_HOLD
    } state_t;

    state_t          state_reg;
    logic [LB-1:0]   n_reg;
    logic [LB-1:0]   d_reg;
    logic [LB:0]     sq_reg;
    logic [CW-1:0]   np_reg;
    logic [CW-1:0]   nm_reg;
    logic [CW-1:0]   used_cnt_reg;
    logic [CW-1:0]   j_reg;
    logic [CW-1:0]   si_reg;
    logic [CW-1:0]   sj_reg;
    logic [CW-1:0]   base_reg;
    logic [CW-1:0]   xi_reg;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   oi_reg;
    logic [CW-1:0]   min_addr_reg;
    logic [LB-1:0]   prod_reg;
    logic [LB-1:0]   min_val_reg;
    logic [LB-1:0]   cur_val_reg;
    logic [LB-1:0]   stride_reg;
    logic            first_reg;
    logic            sort_ret_reg;
    logic            got_reg;
    logic [PS-1:0]   used_reg;

    // prime list and plan list memories
    logic [LB-1:0]   prime_mem [PS];
    logic [LB-1:0]   plan_mem [PS];
    logic [AW-1:0]   pr_addr_reg;
    logic [LB-1:0]   pr_q;
    logic            pr_we_reg;
    logic [AW-1:0]   pr_wa_reg;
    logic [LB-1:0]   pr_wd_reg;
    logic [AW-1:0]   pl_addr_reg;
    logic [LB-1:0]   pl_q;
    logic            pl_we_reg;
    logic [AW-1:0]   pl_wa_reg;
    logic [LB-1:0]   pl_wd_reg;

    logic            mul_start_reg;
    logic [LB-1:0]   mul_a_reg;
    logic [LB-1:0]   mul_b_reg;
    logic            mul_done;
    logic [LB-1:0]   mul_p;
    logic            div_start_reg;
    logic            div_done;
    logic [LB-1:0]   div_q;
    logic [LB-1:0]   div_r;

    logic            out_accept;
    item_kind_t      kind;
    logic [LB-1:0]   q_len;
    logic [XW-1:0]   limit;
    logic [XW-1:0]   nm_x;
    logic [CW-1:0]   pr_rd_idx;
    logic [LB+31:0]  mul_p_w;
    logic [LB+31:0]  pl_q_w;
    logic [LB+31:0]  stride_w;
    logic [LB+31:0]  bound_w;
    logic [LB+31:0]  alpha_w;

    assign out_accept = out_valid && !out_stall;
    assign kind       = item_kind_t'(q_data[LB+1:LB]);
    assign q_len      = q_data[LB-1:0];
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign pr_rd_idx  = np_reg - j_reg - CW'(1);
    assign mul_p_w    = {32'b0, mul_p};
    assign pl_q_w     = {32'b0, pl_q};
    assign stride_w   = {32'b0, stride_reg};
    assign bound_w    = {{LB{1'b0}}, cfg.merge_bound};
    assign alpha_w    = {{LB{1'b0}}, cfg.alpha_threshold};
    assign nm_x       = {5'b0, nm_reg};

    // a stage limit of zero acts as one, above the slot count as the slot count
    always_comb
    begin
        if (cfg.max_stages == 4'd0)
        begin
            limit = XW'(1);
        end
        else if ({{(XW-4){1'b0}}, cfg.max_stages} > XW'(MAX_STAGE_SLOTS))
        begin
            limit = XW'(MAX_STAGE_SLOTS);
        end
        else
        begin
            limit = {{(XW-4){1'b0}}, cfg.max_stages};
        end
    end

    frp_mul #(.W(LB)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    frp_div #(.W(LB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (n_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quo      (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (pr_we_reg)
        begin
            prime_mem[pr_wa_reg] <= pr_wd_reg;
        end
        pr_q <= prime_mem[pr_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pl_we_reg)
        begin
            plan_mem[pl_wa_reg] <= pl_wd_reg;
        end
        pl_q <= plan_mem[pl_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid     <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            pr_we_reg     <= 1'b0;
            pl_we_reg     <= 1'b0;
            got_reg       <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            pr_we_reg     <= 1'b0;
            pl_we_reg     <= 1'b0;
            if (out_accept)
            begin
                out_valid <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        case (kind)
                            KIND_ERR:
                            begin
                                stage_factor  <= 32'd0;
                                stride_before <= 32'd0;
                                stage_index   <= 3'd0;
                                last          <= 1'b1;
                                error         <= 1'b1;
                                out_valid     <= 1'b1;
                                state_reg     <= ST_ERR_HOLD;
                            end
                            KIND_DIRECT:
                            begin
                                pl_we_reg <= 1'b1;
                                pl_wa_reg <= '0;
                                pl_wd_reg <= q_len;
                                nm_reg    <= CW'(1);
                                base_reg  <= '0;
                                state_reg <= ST_OUT_INIT;
                            end
                            default:
                            begin
                                n_reg     <= q_len;
                                d_reg     <= LB'(2);
                                sq_reg    <= (LB+1)'(4);
                                np_reg    <= '0;
                                state_reg <= ST_FAC;
                            end
                        endcase
                    end
                end

                ST_FAC:
                begin
                    if (sq_reg > {1'b0, n_reg})
                    begin
                        if (n_reg != LB'(1))
                        begin
                            pr_we_reg <= 1'b1;
                            pr_wa_reg <= np_reg[AW-1:0];
                            pr_wd_reg <= n_reg;
                            np_reg    <= np_reg + CW'(1);
                        end
                        used_reg     <= '0;
                        used_cnt_reg <= '0;
                        nm_reg       <= '0;
                        state_reg    <= ST_MRG_START;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_FAC_DIV;
                    end
                end

                ST_FAC_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_r == '0)
                        begin
                            pr_we_reg <= 1'b1;
                            pr_wa_reg <= np_reg[AW-1:0];
                            pr_wd_reg <= d_reg;
                            np_reg    <= np_reg + CW'(1);
                            n_reg     <= div_q;
                        end
                        else
                        begin
                            // (d+1)^2 = d^2 + 2d + 1
                            d_reg  <= d_reg + LB'(1);
                            sq_reg <= sq_reg + {d_reg, 1'b1};
                        end
                        state_reg <= ST_FAC;
                    end
                end

                ST_MRG_START:
                begin
                    if (used_cnt_reg == np_reg)
                    begin
                        si_reg       <= '0;
                        sort_ret_reg <= 1'b0;
                        state_reg    <= ST_SO_TOP;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        first_reg <= 1'b1;
                        state_reg <= ST_MRG_RD;
                    end
                end

                ST_MRG_RD:
                begin
                    if (j_reg == np_reg)
                    begin
                        pl_we_reg <= 1'b1;
                        pl_wa_reg <= nm_reg[AW-1:0];
                        pl_wd_reg <= prod_reg;
                        nm_reg    <= nm_reg + CW'(1);
                        state_reg <= ST_MRG_START;
                    end
                    else if (used_reg[j_reg[AW-1:0]])
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        // primes are stored ascending, merge walks them largest first
                        pr_addr_reg <= pr_rd_idx[AW-1:0];
                        state_reg   <= ST_MRG_WAIT;
                    end
                end

                ST_MRG_WAIT:
                begin
                    state_reg <= ST_MRG_CHK;
                end

                ST_MRG_CHK:
                begin
                    if (first_reg)
                    begin
                        prod_reg                <= pr_q;
                        used_reg[j_reg[AW-1:0]] <= 1'b1;
                        used_cnt_reg            <= used_cnt_reg + CW'(1);
                        first_reg               <= 1'b0;
                        j_reg                   <= j_reg + CW'(1);
                        state_reg               <= ST_MRG_RD;
                    end
                    else
                    begin
                        mul_a_reg     <= pr_q;
                        mul_b_reg     <= prod_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MRG_MUL;
                    end
                end

                ST_MRG_MUL:
                begin
                    if (mul_done)
                    begin
                        if (mul_p_w <= bound_w)
                        begin
                            prod_reg                <= mul_p;
                            used_reg[j_reg[AW-1:0]] <= 1'b1;
                            used_cnt_reg            <= used_cnt_reg + CW'(1);
                        end
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= ST_MRG_RD;
                    end
                end

                // selection sort of plan_mem[si .. nm-1], ascending
                ST_SO_TOP:
                begin
                    if ((si_reg + CW'(1)) >= nm_reg)
                    begin
                        state_reg <= sort_ret_reg ? ST_AL_RD0 : ST_LIM;
                    end
                    else
                    begin
                        pl_addr_reg <= si_reg[AW-1:0];
                        state_reg   <= ST_SO_WAIT;
                    end
                end

                ST_SO_WAIT:
                begin
                    state_reg <= ST_SO_GET;
                end

                ST_SO_GET:
                begin
                    cur_val_reg  <= pl_q;
                    min_val_reg  <= pl_q;
                    min_addr_reg <= si_reg;
                    sj_reg       <= si_reg + CW'(1);
                    state_reg    <= ST_SI_RD;
                end

                ST_SI_RD:
                begin
                    if (sj_reg == nm_reg)
                    begin
                        state_reg <= ST_SWAP1;
                    end
                    else
                    begin
                        pl_addr_reg <= sj_reg[AW-1:0];
                        state_reg   <= ST_SI_WAIT;
                    end
                end

                ST_SI_WAIT:
                begin
                    state_reg <= ST_SI_CHK;
                end

                ST_SI_CHK:
                begin
                    if (pl_q < min_val_reg)
                    begin
                        min_val_reg  <= pl_q;
                        min_addr_reg <= sj_reg;
                    end
                    sj_reg    <= sj_reg + CW'(1);
                    state_reg <= ST_SI_RD;
                end

                ST_SWAP1:
                begin
                    pl_we_reg <= 1'b1;
                    pl_wa_reg <= min_addr_reg[AW-1:0];
                    pl_wd_reg <= cur_val_reg;
                    state_reg <= ST_SWAP2;
                end

                ST_SWAP2:
                begin
                    pl_we_reg <= 1'b1;
                    pl_wa_reg <= si_reg[AW-1:0];
                    pl_wd_reg <= min_val_reg;
                    si_reg    <= si_reg + CW'(1);
                    state_reg <= ST_SO_TOP;
                end

                ST_LIM:
                begin
                    if (nm_x > limit)
                    begin
                        base_reg  <= nm_reg - limit[CW-1:0];
                        xi_reg    <= '0;
                        state_reg <= ST_EX_TOP;
                    end
                    else
                    begin
                        base_reg  <= '0;
                        state_reg <= ST_AL_RD0;
                    end
                end

                // fold each surplus small factor into the current minimum
                ST_EX_TOP:
                begin
                    if (xi_reg == base_reg)
                    begin
                        si_reg       <= base_reg;
                        sort_ret_reg <= 1'b1;
                        state_reg    <= ST_SO_TOP;
                    end
                    else
                    begin
                        sj_reg    <= base_reg;
                        state_reg <= ST_EX_RD;
                    end
                end

                ST_EX_RD:
                begin
                    if (sj_reg == nm_reg)
                    begin
                        state_reg <= ST_EX_RDX;
                    end
                    else
                    begin
                        pl_addr_reg <= sj_reg[AW-1:0];
                        state_reg   <= ST_EX_WAIT;
                    end
                end

                ST_EX_WAIT:
                begin
                    state_reg <= ST_EX_CHK;
                end

                ST_EX_CHK:
                begin
                    if ((sj_reg == base_reg) || (pl_q < min_val_reg))
                    begin
                        min_val_reg  <= pl_q;
                        min_addr_reg <= sj_reg;
                    end
                    sj_reg    <= sj_reg + CW'(1);
                    state_reg <= ST_EX_RD;
                end

                ST_EX_RDX:
                begin
                    pl_addr_reg <= xi_reg[AW-1:0];
                    state_reg   <= ST_EX_WX;
                end

                ST_EX_WX:
                begin
                    state_reg <= ST_EX_MUL;
                end

                ST_EX_MUL:
                begin
                    mul_a_reg     <= min_val_reg;
                    mul_b_reg     <= pl_q;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_EX_MW;
                end

                ST_EX_MW:
                begin
                    if (mul_done)
                    begin
                        pl_we_reg <= 1'b1;
                        pl_wa_reg <= min_addr_reg[AW-1:0];
                        pl_wd_reg <= mul_p;
                        xi_reg    <= xi_reg + CW'(1);
                        state_reg <= ST_EX_TOP;
                    end
                end

                // bring the first factor of at least alpha to the front
                ST_AL_RD0:
                begin
                    if ((nm_reg - base_reg) <= CW'(1))
                    begin
                        state_reg <= ST_OUT_INIT;
                    end
                    else
                    begin
                        pl_addr_reg <= base_reg[AW-1:0];
                        state_reg   <= ST_AL_W0;
                    end
                end

                ST_AL_W0:
                begin
                    state_reg <= ST_AL_G0;
                end

                ST_AL_G0:
                begin
                    cur_val_reg <= pl_q;
                    if (pl_q_w >= alpha_w)
                    begin
                        state_reg <= ST_OUT_INIT;
                    end
                    else
                    begin
                        sj_reg    <= base_reg + CW'(1);
                        state_reg <= ST_AL_RD;
                    end
                end

                ST_AL_RD:
                begin
                    if (sj_reg == nm_reg)
                    begin
                        state_reg <= ST_OUT_INIT;
                    end
                    else
                    begin
                        pl_addr_reg <= sj_reg[AW-1:0];
                        state_reg   <= ST_AL_WAIT;
                    end
                end

                ST_AL_WAIT:
                begin
                    state_reg <= ST_AL_CHK;
                end

                ST_AL_CHK:
                begin
                    if (pl_q_w >= alpha_w)
                    begin
                        pl_we_reg <= 1'b1;
                        pl_wa_reg <= base_reg[AW-1:0];
                        pl_wd_reg <= pl_q;
                        state_reg <= ST_AL_SW2;
                    end
                    else
                    begin
                        sj_reg    <= sj_reg + CW'(1);
                        state_reg <= ST_AL_RD;
                    end
                end

                ST_AL_SW2:
                begin
                    pl_we_reg <= 1'b1;
                    pl_wa_reg <= sj_reg[AW-1:0];
                    pl_wd_reg <= cur_val_reg;
                    state_reg <= ST_OUT_INIT;
                end

                ST_OUT_INIT:
                begin
                    k_reg      <= base_reg;
                    oi_reg     <= '0;
                    stride_reg <= LB'(1);
                    got_reg    <= 1'b0;
                    state_reg  <= ST_OUT_RD;
                end

                ST_OUT_RD:
                begin
                    pl_addr_reg <= k_reg[AW-1:0];
                    state_reg   <= ST_OUT_WAIT;
                end

                ST_OUT_WAIT:
                begin
                    state_reg <= ST_OUT_SET;
                end

                ST_OUT_SET:
                begin
                    stage_factor  <= pl_q_w[31:0];
                    stride_before <= stride_w[31:0];
                    stage_index   <= oi_reg[2:0];
                    last          <= ((k_reg + CW'(1)) == nm_reg);
                    error         <= 1'b0;
                    out_valid     <= 1'b1;
                    mul_a_reg     <= stride_reg;
                    mul_b_reg     <= pl_q;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_OUT_HOLD;
                end

                ST_OUT_HOLD:
                begin
                    if (mul_done)
                    begin
                        stride_reg <= mul_p;
                    end
                    if ((got_reg || mul_done) && (!out_valid || out_accept))
                    begin
                        got_reg <= 1'b0;
                        if ((k_reg + CW'(1)) == nm_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CW'(1);
                            oi_reg    <= oi_reg + CW'(1);
                            state_reg <= ST_OUT_RD;
                        end
                    end
                    else if (mul_done)
                    begin
                        got_reg <= 1'b1;
                    end
                end

                ST_ERR_HOLD:
                begin
                    if (!out_valid || out_accept)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/frp_checker.sv -----
// Port-level checks on the planner's result channel, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module frp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] stage_factor,
    input wire logic [31:0] stride_before,
    input wire logic [2:0]  stage_index,
    input wire logic        last,
    input wire logic        error
);
    // an error item is always the whole plan
    `ASSERT_IMPL(a_err_last, out_valid && error, last)
    `ASSERT_IMPL(a_err_zero, out_valid && error,
        stage_factor == 32'd0 && stride_before == 32'd0 && stage_index == 3'd0)
    `ASSERT_NEXT(a_hold, out_valid && out_stall,
        out_valid && $stable(stage_factor) && $stable(stride_before) && $stable(last))
endmodule

bind fft_radix_factor_planner_top frp_checker u_frp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stage_factor  (stage_factor),
    .stride_before (stride_before),
    .stage_index   (stage_index),
    .last          (last),
    .error         (error)
);
`default_nettype wire

// ----- tb/frp_plan_checker.sv -----
// Checker for the FFT radix factor planner: follows register writes, predicts the stage
// items for every accepted length and compares them with the result channel.
// Depends on frp_pkg.
`timescale 1ns / 100ps
module frp_plan_checker
    import frp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] length,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] stage_factor,
    input  logic [31:0] stride_before,
    input  logic [2:0]  stage_index,
    input  logic        last,
    input  logic        error,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [31:0] factor;
        logic [31:0] stride;
        logic [2:0]  idx;
        logic        last;
        logic        err;
    } stage_t;

    typedef longint unsigned u64_t;

    stage_t stage_q[$];
    cfg_t   cfg;

    function automatic void sort_ascending(ref u64_t v[0:32], input int n);
        u64_t x;
        int   j;
        for (int i = 1; i < n; i++)
        begin
            x = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > x)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = x;
        end
    endfunction

    function automatic void predict_stages(logic [31:0] len);
        u64_t   n;
        u64_t   d;
        u64_t   prod;
        u64_t   stride;
        u64_t   tmp;
        u64_t   primes[0:32];
        u64_t   desc[0:32];
        u64_t   merged[0:32];
        u64_t   plan[0:32];
        bit     used[0:32];
        int     np;
        int     nm;
        int     lim;
        int     extra;
        int     m;
        stage_t s;
        n = len;
        np = 0;
        nm = 0;
        if (n < 2)
        begin
            s = '{factor: 0, stride: 0, idx: 0, last: 1'b1, err: 1'b1};
            stage_q.insert(stage_q.size(), s);
            return;
        end
        if (n <= u64_t'(cfg.direct_limit))
        begin
            plan[0] = n;
            nm = 1;
        end
        else
        begin
            // trial division, primes come out ascending
            d = 2;
            while (d * d <= n)
            begin
                if (n % d == 0)
                begin
                    primes[np++] = d;
                    n = n / d;
                end
                else
                    d++;
            end
            if (n != 1)
                primes[np++] = n;
            for (int i = 0; i < np; i++)
            begin
                desc[i] = primes[np - 1 - i];
                used[i] = 1'b0;
            end
            // greedy merge, largest primes first
            for (int i = 0; i < np; i++)
            begin
                prod = 1;
                for (int j = i; j < np; j++)
                begin
                    if (!used[j] && (prod == 1 || desc[j] * prod <= u64_t'(cfg.merge_bound)))
                    begin
                        prod = prod * desc[j];
                        used[j] = 1'b1;
                    end
                end
                if (prod == 1)
                    break;
                merged[nm++] = prod;
            end
            sort_ascending(merged, nm);
            lim = cfg.max_stages;
            if (lim < 1)
                lim = 1;
            if (lim > 8)
                lim = 8;
            if (nm > lim)
            begin
                extra = nm - lim;
                for (int i = 0; i < lim; i++)
                    plan[i] = merged[extra + i];
                // fold each surplus small factor into the current minimum
                for (int i = 0; i < extra; i++)
                begin
                    m = 0;
                    for (int j = 1; j < lim; j++)
                        if (plan[j] < plan[m])
                            m = j;
                    plan[m] = plan[m] * merged[i];
                end
                nm = lim;
                sort_ascending(plan, nm);
            end
            else
            begin
                for (int i = 0; i < nm; i++)
                    plan[i] = merged[i];
            end
            if (nm > 1 && plan[0] < u64_t'(cfg.alpha_threshold))
            begin
                for (int i = 1; i < nm; i++)
                begin
                    if (plan[i] >= u64_t'(cfg.alpha_threshold))
                    begin
                        tmp = plan[0];
                        plan[0] = plan[i];
                        plan[i] = tmp;
                        break;
                    end
                end
            end
        end
        stride = 1;
        for (int k = 0; k < nm; k++)
        begin
            s.factor = plan[k][31:0];
            s.stride = stride[31:0];
            s.idx    = k[2:0];
            s.last   = (k == nm - 1);
            s.err    = 1'b0;
            stage_q.insert(stage_q.size(), s);
            stride = stride * plan[k];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stage_t exp_s;
        if (!rst_n)
        begin
            cfg.direct_limit    <= RST_DIRECT_LIMIT;
            cfg.merge_bound     <= RST_MERGE_BOUND;
            cfg.max_stages      <= RST_MAX_STAGES;
            cfg.alpha_threshold <= RST_ALPHA;
            fail_count          <= 0;
            pending             <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DIRECT_LIMIT: cfg.direct_limit    <= cfg_wdata;
                    CFG_MERGE_BOUND:  cfg.merge_bound     <= cfg_wdata;
                    CFG_MAX_STAGES:   cfg.max_stages      <= cfg_wdata[3:0];
                    CFG_ALPHA:        cfg.alpha_threshold <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_stages(length);
            if (out_valid && !out_stall)
            begin
                if (stage_q.size() == 0)
                begin
                    $error("unexpected item: stage_factor %0d", stage_factor);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_s = stage_q.pop_front();
                    if (stage_factor !== exp_s.factor || stride_before !== exp_s.stride ||
                        stage_index !== exp_s.idx || last !== exp_s.last ||
                        error !== exp_s.err)
                        fail_count <= fail_count + 1;
                    if (stage_factor !== exp_s.factor)
                        $error("stage_factor: expected %0d, got %0d", exp_s.factor, stage_factor);
                    if (stride_before !== exp_s.stride)
                        $error("stride_before: expected %0d, got %0d", exp_s.stride,
                               stride_before);
                    if (stage_index !== exp_s.idx)
                        $error("stage_index: expected %0d, got %0d", exp_s.idx, stage_index);
                    if (last !== exp_s.last)
                        $error("last: expected %0d, got %0d", exp_s.last, last);
                    if (error !== exp_s.err)
                        $error("error: expected %0d, got %0d", exp_s.err, error);
                end
            end
            pending <= stage_q.size();
        end
    end
endmodule

// ----- tb/tb_fft_radix_factor_planner_top.sv -----
// Testbench top of the FFT radix factor planner: clock, reset, lengths and register writes.
// Depends on frp_pkg, fft_radix_factor_planner_top and frp_plan_checker.
`timescale 1ns / 100ps
module tb_fft_radix_factor_planner_top;
    import frp_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;
    localparam int     SETTLE      = 6000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_DIRECT_LIMIT;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] stage_factor;
    logic [31:0] stride_before;
    logic [2:0]  stage_index;
    logic        last;
    logic        error;
    int          fail_count;
    int          pending;
    longint      cycles = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    fft_radix_factor_planner_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .stage_factor(stage_factor), .stride_before(stride_before),
        .stage_index(stage_index), .last(last), .error(error)
    );

    frp_plan_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .stage_factor(stage_factor), .stride_before(stride_before),
        .stage_index(stage_index), .last(last), .error(error),
        .fail_count(fail_count), .pending(pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // result-side stalls: mostly short bursts, now and then a long one
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 30)
        begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : 0;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_length(logic [31:0] v);
        int gap;
        in_valid <= 1'b1;
        length   <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            length   <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] dl, logic [31:0] fb, logic [31:0] ms,
                              logic [31:0] al);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DIRECT_LIMIT;
        cfg_wdata <= dl;
        @(posedge clk);
        cfg_index <= CFG_MERGE_BOUND;
        cfg_wdata <= fb;
        @(posedge clk);
        cfg_index <= CFG_MAX_STAGES;
        cfg_wdata <= ms;
        @(posedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_wdata <= al;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // smooth lengths keep trial division short; a few get a mid-size prime
    function automatic logic [31:0] random_length();
        int unsigned small_p[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        int unsigned mid_p[6]    = '{101, 251, 509, 1021, 4093, 65521};
        longint unsigned n;
        longint unsigned p;
        int steps;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 300);
        n = ($urandom_range(0, 3) == 0) ? mid_p[$urandom_range(0, 5)] : 1;
        steps = $urandom_range(1, 24);
        for (int i = 0; i < steps; i++)
        begin
            p = small_p[$urandom_range(0, 10)];
            if (n * p > 64'hFFFF_FFFF)
                break;
            n = n * p;
        end
        return n[31:0];
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_length(random_length());
        drain();
    endtask

    initial
    begin
        logic [31:0] directed[$] = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd128, 32'd129, 32'd256, 32'd1024,
            32'hFFFF_FFFF, 32'h8000_0000, 32'd720720, 32'd223092870, 32'd65521,
            32'd670097, 32'd4096 * 32'd243, 32'd131072, 32'd3 * 32'd65521, 32'd2310,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b0;
        foreach (directed[i])
            send_length(directed[i]);
        drain();
        idle_on = 1'b1;
        random_phase(12);

        // lowest settings: every length factored, single stage, zero merge bound
        write_regs(32'd0, 32'd0, 32'd0, 32'd1);
        foreach (directed[i])
            send_length(directed[i]);
        random_phase(8);

        write_regs(32'd2, 32'd2, 32'd1, 32'd1);
        random_phase(6);

        // highest settings: everything direct, then factored with huge bound
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15, 32'hFFFF_FFFF);
        random_phase(6);
        write_regs(32'd1, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFFF);
        random_phase(6);

        write_regs(32'd16, 32'd8, 32'd3, 32'd5);
        for (int i = 0; i < 4; i++)
            send_length(directed[i + 8]);
        random_phase(8);

        write_regs($urandom_range(2, 1000), $urandom_range(2, 300), $urandom_range(0, 15),
                   $urandom_range(1, 64));
        idle_on = 1'b0;
        random_phase(10);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
